/* sv/otgs_pkg.sv */
// Shared types, constants and the 5x8 font table of the text glyph streamer.
package otgs_pkg;

  localparam int DEF_COLUMNS     = 128;
  localparam int DEF_PAGES       = 8;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int GLYPH_W   = 5;
  localparam int PAGE_W    = 3;
  localparam int COL_W     = 8;
  localparam int CODE_W    = 8;
  localparam int GIDX_W    = 7;
  localparam int GLYPHS    = 95;
  localparam int STEP_W    = 4;

  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_FIRST   = 8'h20;
  localparam logic [CODE_W-1:0] CODE_LAST    = 8'h7E;

  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] BLANK_COLUMN  = 8'h00;

  // Step numbers of the output sequencer.
  localparam logic [STEP_W-1:0] STEP_COL_CMD   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COL_START = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COL_END   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PAGE_CMD  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_PAGE_ST   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_PAGE_END  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_GLYPH0    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_GLYPH1    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_GLYPH2    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_GLYPH3    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_GLYPH4    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_BLANK     = 4'd11;

  // One classified job: an optional window setup followed by an optional glyph.
  typedef struct packed {
    logic              has_win;
    logic              has_glyph;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic [GIDX_W-1:0] glyph_idx;
  } job_t;

  // Font rows, first column in the top byte.
  localparam logic [39:0] GLYPH_ROM [GLYPHS] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h1CA0A0A07C, 40'h4464544C44, 40'h00107C8200,
    40'h0000FF0000, 40'h00827C1000, 40'h0006090906
  };

  function automatic logic [39:0] glyph_row(input logic [GIDX_W-1:0] idx);
    logic [39:0] row;
    row = '0;
    if (int'(idx) < GLYPHS) row = GLYPH_ROM[idx];
    return row;
  endfunction

endpackage

/* sv/oled_text_glyph_streamer.sv */
// Top level: glyph streamer for a page-organized monochrome display controller.
// With the sequencer idle, an accepted item is queued first, then its first byte is loaded into the output register.
// Throughput: one output byte per cycle while the output does not stall; a character is 6 bytes, or 12 with a
// page move; a set-cursor item and a newline are 6 bytes, a rejected set-cursor none.
// The byte sequencer (one byte per cycle unless the output stalls) sets the rate; a job queue decouples input.
// Reset: cursor to page 0, column 0; queue and output register empty.
module oled_text_glyph_streamer #(
  parameter int COLUMNS     = otgs_pkg::DEF_COLUMNS,
  parameter int PAGES       = otgs_pkg::DEF_PAGES,
  parameter int QUEUE_DEPTH = otgs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] target_page_i,
  input  logic [7:0] target_column_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_data_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);
  import otgs_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  otgs_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .char_code_i     (char_code_i),
    .target_page_i   (target_page_i),
    .target_column_i (target_column_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_job_o      (push_job)
  );

  otgs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_job_o (head_job),
    .empty_o    (q_empty)
  );

  otgs_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_data_o   (is_data_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

/* sv/otgs_queue.sv */
// Small job queue between the classifier and the byte sequencer.
module otgs_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  otgs_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output otgs_pkg::job_t head_job_o,
  output logic          empty_o
);
  import otgs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

/* sv/otgs_front.sv */
// Input side: tracks the cursor and classifies each item into a job.
module otgs_front #(
  parameter int COLUMNS = otgs_pkg::DEF_COLUMNS,
  parameter int PAGES   = otgs_pkg::DEF_PAGES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           command_i,
  input  logic [7:0]     char_code_i,
  input  logic [7:0]     target_page_i,
  input  logic [7:0]     target_column_i,
  input  logic           q_full_i,
  output logic           push_o,
  output otgs_pkg::job_t push_job_o
);
  import otgs_pkg::*;

  logic [PAGE_W-1:0] page_q, page_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              accept;
  logic              in_range;
  logic              is_newline;
  logic              no_fit;
  logic              in_font;
  logic [PAGE_W-1:0] next_page;
  logic [COL_W-1:0]  base_col;
  logic [COL_W:0]    fit_sum;
  job_t              job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign in_range   = (target_page_i <= 8'(PAGES - 1)) && (target_column_i < 8'(COLUMNS));
  assign is_newline = (char_code_i == CODE_NEWLINE);
  assign fit_sum    = {1'b0, col_q} + (COL_W + 1)'(GLYPH_W);
  assign no_fit     = (fit_sum >= (COL_W + 1)'(COLUMNS));
  assign in_font    = (char_code_i >= CODE_FIRST) && (char_code_i <= CODE_LAST);
  assign next_page  = (page_q == PAGE_W'(PAGES - 1)) ? '0 : page_q + 1'b1;

  always_comb begin
    job      = '0;
    page_d   = page_q;
    col_d    = col_q;
    base_col = col_q;
    push_o   = 1'b0;
    if (command_i) begin
      job.has_win = 1'b1;
      job.page    = target_page_i[PAGE_W-1:0];
      job.col     = target_column_i;
      if (accept && in_range) begin
        push_o = 1'b1;
        page_d = target_page_i[PAGE_W-1:0];
        col_d  = target_column_i;
      end
    end else begin
      // Wrap to the next page on newline or when the glyph and its blank column would not fit.
      if (is_newline || no_fit) begin
        job.has_win = 1'b1;
        job.page    = next_page;
        job.col     = '0;
        base_col    = '0;
      end
      job.has_glyph = !is_newline;
      job.glyph_idx = in_font ? GIDX_W'(char_code_i - CODE_FIRST) : '0;
      if (accept) begin
        push_o = 1'b1;
        if (job.has_win) page_d = next_page;
        col_d = is_newline ? base_col : base_col + COL_W'(GLYPH_W + 1);
      end
    end
  end

  assign push_job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      col_q  <= '0;
    end else begin
      page_q <= page_d;
      col_q  <= col_d;
    end
  end

  a_page_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_q <= PAGE_W'(PAGES - 1)) else $error("cursor page out of range");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} <= (COL_W + 1)'(COLUMNS)) else $error("cursor column out of range");
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (push_job_o.has_win || push_job_o.has_glyph))
    else $error("empty job pushed");

endmodule

/* sv/otgs_back.sv */
// Output side: walks each queued job and emits one byte per cycle unless the output stalls.
module otgs_back #(
  parameter int COLUMNS = otgs_pkg::DEF_COLUMNS,
  parameter int PAGES   = otgs_pkg::DEF_PAGES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  otgs_pkg::job_t head_job_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           is_data_o,
  output logic [7:0]     out_byte_o,
  output logic           last_o
);
  import otgs_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              vld_q, vld_d;
  logic              is_data_q;
  logic [7:0]        byte_q;
  logic              last_q;

  logic              fire;
  logic [STEP_W-1:0] cur_step;
  logic [STEP_W-1:0] end_step;
  logic [39:0]       row;
  logic [7:0]        cur_byte;
  logic              cur_last;

  // Produce when a job waits and the output register is free or draining.
  assign fire     = !q_empty_i && (!vld_q || !out_stall_i);
  assign cur_step = busy_q ? step_q : (head_job_i.has_win ? STEP_COL_CMD : STEP_GLYPH0);
  assign end_step = head_job_i.has_glyph ? STEP_BLANK : STEP_PAGE_END;
  assign cur_last = (cur_step == end_step);
  assign row      = glyph_row(head_job_i.glyph_idx);
  assign pop_o    = fire && cur_last;

  always_comb begin
    case (cur_step)
      STEP_COL_CMD:   cur_byte = CMD_COL_ADDR;
      STEP_COL_START: cur_byte = head_job_i.col;
      STEP_COL_END:   cur_byte = 8'(COLUMNS - 1);
      STEP_PAGE_CMD:  cur_byte = CMD_PAGE_ADDR;
      STEP_PAGE_ST:   cur_byte = 8'(head_job_i.page);
      STEP_PAGE_END:  cur_byte = 8'(PAGES - 1);
      STEP_GLYPH0:    cur_byte = row[39:32];
      STEP_GLYPH1:    cur_byte = row[31:24];
      STEP_GLYPH2:    cur_byte = row[23:16];
      STEP_GLYPH3:    cur_byte = row[15:8];
      STEP_GLYPH4:    cur_byte = row[7:0];
      STEP_BLANK:     cur_byte = BLANK_COLUMN;
      default:        cur_byte = BLANK_COLUMN;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    vld_d  = vld_q && out_stall_i;
    if (fire) begin
      vld_d  = 1'b1;
      busy_d = !cur_last;
      step_d = cur_step + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      is_data_q <= (cur_step >= STEP_GLYPH0);
      byte_q    <= cur_byte;
      last_q    <= cur_last;
    end
  end

  assign out_valid_o = vld_q;
  assign is_data_o   = is_data_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !q_empty_i) else $error("sequencer busy without a job");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= STEP_BLANK)) else $error("sequencer step out of range");
  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && last_q && !is_data_q) |-> (byte_q == 8'(PAGES - 1)))
    else $error("command transaction ends on wrong byte");
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && last_q && is_data_q) |-> (byte_q == BLANK_COLUMN))
    else $error("glyph transaction ends on wrong byte");

endmodule

/* bench/otgs_checker.sv */
// Bench command codes and the checker that predicts and compares the byte stream.
`timescale 1ns / 1ps

package otgs_bench_pkg;
  typedef enum logic {
    CMD_PRINT  = 1'b0,
    CMD_CURSOR = 1'b1
  } command_e;
endpackage

module otgs_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       command_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] target_page_i,
  input  logic [7:0] target_column_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       is_data_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);
  import otgs_pkg::*;
  import otgs_bench_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int PAGES   = DEF_PAGES;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } disp_byte_t;

  // 5x8 font, codes 0x20..0x7E, first column in the top byte.
  localparam logic [39:0] FONT_COLS [95] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h1CA0A0A07C, 40'h4464544C44, 40'h00107C8200,
    40'h0000FF0000, 40'h00827C1000, 40'h0006090906
  };

  disp_byte_t  expected_bytes [$];
  logic [2:0]  cur_page;
  logic [7:0]  cur_col;
  int          mismatches;

  function automatic void push_byte(input logic is_data, input logic [7:0] value);
    disp_byte_t b;
    b.is_data = is_data;
    b.value   = value;
    b.last    = 1'b0;
    expected_bytes.push_back(b);
  endfunction

  function automatic void push_window(input logic [2:0] page, input logic [7:0] col);
    push_byte(1'b0, CMD_COL_ADDR);
    push_byte(1'b0, col);
    push_byte(1'b0, 8'(COLUMNS - 1));
    push_byte(1'b0, CMD_PAGE_ADDR);
    push_byte(1'b0, {5'b0, page});
    push_byte(1'b0, 8'(PAGES - 1));
  endfunction

  function automatic void predict_bytes(input logic cmd, input logic [7:0] code,
                                        input logic [7:0] tpage, input logic [7:0] tcol);
    logic [39:0] cols;
    int          first;
    first = expected_bytes.size();
    if (cmd == CMD_CURSOR) begin
      if (int'(tpage) <= PAGES - 1 && int'(tcol) < COLUMNS) begin
        cur_page = tpage[2:0];
        cur_col  = tcol;
        push_window(tpage[2:0], tcol);
      end
    end else begin
      // Move to the next page on newline or when the glyph and its blank column would not fit.
      if (code == CODE_NEWLINE || int'(cur_col) + GLYPH_W >= COLUMNS) begin
        cur_page = 3'((int'(cur_page) + 1) % PAGES);
        cur_col  = 8'h00;
        push_window(cur_page, 8'h00);
      end
      if (code != CODE_NEWLINE) begin
        cols = '0;
        if (code >= CODE_FIRST && code <= CODE_LAST) cols = FONT_COLS[code - CODE_FIRST];
        for (int k = 0; k < GLYPH_W; k++) push_byte(1'b1, cols[39 - 8 * k -: 8]);
        push_byte(1'b1, BLANK_COLUMN);
        cur_col = cur_col + 8'(GLYPH_W + 1);
      end
    end
    if (expected_bytes.size() > first) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    disp_byte_t want;
    if (!rst_ni) begin
      expected_bytes.delete();
      cur_page     = '0;
      cur_col      = '0;
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        predict_bytes(command_i, char_code_i, target_page_i, target_column_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: unexpected transaction, actual %02h", out_byte_i);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (is_data_i !== want.is_data) begin
            $error("is_data: expected %0d, actual %0d", want.is_data, is_data_i);
            mismatches++;
          end
          if (out_byte_i !== want.value) begin
            $error("out_byte: expected %02h, actual %02h", want.value, out_byte_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_bytes.size();
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the bench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
  import otgs_pkg::*;
  import otgs_bench_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int PAGES       = DEF_PAGES;
  localparam int CHAR_ITEMS  = 380;
  localparam int CYCLE_LIMIT = 1000000;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid      = 1'b0;
  logic       command       = 1'b0;
  logic [7:0] char_code     = 8'h00;
  logic [7:0] target_page   = 8'h00;
  logic [7:0] target_column = 8'h00;
  logic       out_stall     = 1'b0;
  logic       calm          = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       is_data;
  logic [7:0] out_byte;
  logic       out_last;
  int         fail_count;
  int         pending;
  int         cycles        = 0;
  int         stall_left    = 0;

  always #1 clk_i = ~clk_i;

  oled_text_glyph_streamer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .char_code_i    (char_code),
    .target_page_i  (target_page),
    .target_column_i(target_column),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .is_data_o      (is_data),
    .out_byte_o     (out_byte),
    .last_o         (out_last)
  );

  otgs_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .char_code_i    (char_code),
    .target_page_i  (target_page),
    .target_column_i(target_column),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .is_data_i      (is_data),
    .out_byte_i     (out_byte),
    .last_i         (out_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Receiver stalls: mostly none, some short bursts, a few long ones.
  always @(posedge clk_i) begin : stall_gen
    int pick;
    if (!rst_ni || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        out_stall <= 1'b0;
      end else if (pick < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(7, 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      cycles <= cycles + 1;
    end
  end

  // Call at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input command_e cmd, input logic [7:0] code,
                           input logic [7:0] tpage, input logic [7:0] tcol);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap  = 0;
    if (!calm) begin
      if (pick >= 90) gap = $urandom_range(10, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    char_code     <= code;
    target_page   <= tpage;
    target_column <= tcol;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic print_char(input logic [7:0] code);
    send_item(CMD_PRINT, code, 8'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    int         counted;
    int         pick;
    command_e   cmd;
    logic [7:0] code;
    logic [7:0] tpage;
    logic [7:0] tcol;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Font extremes, codes outside the font, newline.
    print_char(CODE_FIRST);
    print_char(CODE_LAST);
    print_char(8'h00);
    print_char(8'hFF);
    print_char(8'h1F);
    print_char(8'h7F);
    print_char(8'h80);
    print_char(CODE_NEWLINE);
    print_char(8'h41);
    // Cursor at the far corner, then overflow the row and wrap the page.
    send_item(CMD_CURSOR, 8'($urandom), 8'(PAGES - 1), 8'(COLUMNS - 1));
    print_char(8'h42);
    send_item(CMD_CURSOR, 8'($urandom), 8'(PAGES - 1), 8'(COLUMNS - 6));
    print_char(8'h55);
    print_char(8'hAA);
    send_item(CMD_CURSOR, 8'($urandom), 8'(PAGES - 1), 8'h10);
    print_char(CODE_NEWLINE);
    // Rejected cursor moves must keep the cursor.
    send_item(CMD_CURSOR, 8'($urandom), 8'(PAGES), 8'h00);
    send_item(CMD_CURSOR, 8'($urandom), 8'h00, 8'(COLUMNS));
    send_item(CMD_CURSOR, 8'hFF, 8'hFF, 8'hFF);
    print_char(8'h7A);
    send_item(CMD_CURSOR, 8'h00, 8'h00, 8'h00);
    print_char(8'h30);

    counted = 0;
    while (counted < CHAR_ITEMS) begin
      pick  = $urandom_range(0, 99);
      cmd   = CMD_PRINT;
      code  = 8'($urandom);
      tpage = 8'($urandom);
      tcol  = 8'($urandom);
      if (pick < 65) begin
        code = 8'($urandom_range(int'(CODE_FIRST), int'(CODE_LAST)));
      end else if (pick < 75) begin
        code = CODE_NEWLINE;
      end else if (pick >= 83 && pick < 95) begin
        cmd   = CMD_CURSOR;
        tpage = 8'($urandom_range(0, PAGES - 1));
        if ($urandom_range(0, 1) == 0) tcol = 8'($urandom_range(COLUMNS - 8, COLUMNS - 1));
        else tcol = 8'($urandom_range(0, COLUMNS - 1));
      end else if (pick >= 95) begin
        cmd = CMD_CURSOR;
      end
      send_item(cmd, code, tpage, tcol);
      if (!(cmd == CMD_CURSOR && (int'(tpage) > PAGES - 1 || int'(tcol) >= COLUMNS)))
        counted++;
      if ($urandom_range(0, 39) == 0) calm <= ~calm;
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Let the checker see the last transaction before draining.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* oled_text_glyph_streamer.f */
sv/otgs_pkg.sv
sv/otgs_queue.sv
sv/otgs_front.sv
sv/otgs_back.sv
sv/oled_text_glyph_streamer.sv
bench/otgs_checker.sv
bench/testbench.sv
